>>> hw/rtl/srrr_pkg.sv
// shared types and constants of the selective repeat reorder receiver
// used by srrr_ctrl, srrr_dp and selective_repeat_reorder_receiver
package srrr_pkg;

   localparam int SLOTS      = 8;
   localparam int SEQ_BITS   = 16;
   localparam int TAG_BITS   = 16;
   localparam int CFG_BITS   = 4;
   localparam int INITSEQID  = 0;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W      = SLOT_IDX_W + CFG_BITS;

   localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(8);

   localparam logic KIND_ACK = 1'b0;
   localparam logic KIND_DLV = 1'b1;

   typedef enum logic [1:0] {
      EMIT_SELF_DLV,
      EMIT_SELF_ACK,
      EMIT_SLOT_DLV
   } emit_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
      logic         store_slot;
      logic         clear_match;
      logic         inc_expected;
   } cmd_type;

   typedef struct packed {
      logic accepted;
      logic in_order;
      logic future;
      logic dup;
      logic free_found;
      logic match_cur;
      logic match_nxt;
      logic out_free;
   } sts_type;

endpackage

>>> hw/rtl/srrr_dp.sv
// datapath: request registers, expected number, reorder slots, result register
// depends on srrr_pkg
module srrr_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [srrr_pkg::SEQ_BITS-1:0]    req_frame_seq,
   input  logic [srrr_pkg::TAG_BITS-1:0]    req_payload_tag,
   input  logic                             req_accepted,
   input  logic                             csr_wr_en,
   input  logic [srrr_pkg::CFG_BITS-1:0]    csr_wr_data,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic                             rsp_result_kind,
   output logic [srrr_pkg::SEQ_BITS-1:0]    rsp_result_seq,
   output logic [srrr_pkg::TAG_BITS-1:0]    rsp_result_tag,
   output logic                             rsp_last_result,
   input  srrr_pkg::cmd_type                cmd,
   output srrr_pkg::sts_type                sts
);
   import srrr_pkg::*;

   logic [SEQ_BITS-1:0]   frame_seq_ff;
   logic [TAG_BITS-1:0]   payload_tag_ff;
   logic                  accepted_ff;
   logic [SEQ_BITS-1:0]   expected_ff;
   logic [SEQ_BITS-1:0]   expected_in;
   logic [CFG_BITS-1:0]   slots_in_use_ff;
   logic [SLOTS-1:0]      slot_valid_ff;
   logic [SLOTS-1:0]      slot_valid_in;
   logic [SEQ_BITS-1:0]   slot_seq_ff [SLOTS];
   logic [TAG_BITS-1:0]   slot_tag_ff [SLOTS];
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_kind_ff;
   logic [SEQ_BITS-1:0]   rsp_seq_ff;
   logic [TAG_BITS-1:0]   rsp_tag_ff;
   logic                  rsp_last_ff;

   logic [SEQ_BITS-1:0]   diff;
   logic [SEQ_BITS-1:0]   expected_nxt;
   logic [SLOTS-1:0]      active;
   logic [SLOTS-1:0]      hit_cur;
   logic [SLOTS-1:0]      hit_nxt;
   logic [SLOTS-1:0]      hit_dup;
   logic [SLOTS-1:0]      is_free;
   logic [SLOT_IDX_W-1:0] match_idx;
   logic [SLOT_IDX_W-1:0] free_idx;
   logic                  out_free;

   assign diff         = frame_seq_ff - expected_ff;
   assign expected_nxt = expected_ff + 1'b1;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         active[i]  = CMP_W'(i) < CMP_W'(slots_in_use_ff);
         hit_cur[i] = active[i] && slot_valid_ff[i] && (slot_seq_ff[i] == expected_ff);
         hit_nxt[i] = active[i] && slot_valid_ff[i] && (slot_seq_ff[i] == expected_nxt);
         hit_dup[i] = active[i] && slot_valid_ff[i] && (slot_seq_ff[i] == frame_seq_ff);
         is_free[i] = active[i] && !slot_valid_ff[i];
      end
   end

   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit_cur[i]) begin
            match_idx = SLOT_IDX_W'(i);
         end
         if (is_free[i]) begin
            free_idx = SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      sts.accepted   = accepted_ff;
      sts.in_order   = (diff == '0);
      sts.future     = (diff != '0) && !diff[SEQ_BITS-1];
      sts.dup        = |hit_dup;
      sts.free_found = |is_free;
      sts.match_cur  = |hit_cur;
      sts.match_nxt  = |hit_nxt;
      sts.out_free   = out_free;
   end

   always_comb begin
      expected_in   = cmd.inc_expected ? expected_nxt : expected_ff;
      slot_valid_in = slot_valid_ff;
      if (cmd.store_slot) begin
         slot_valid_in[free_idx] = 1'b1;
      end
      if (cmd.clear_match) begin
         slot_valid_in[match_idx] = 1'b0;
      end
      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff     <= SEQ_BITS'(INITSEQID);
         slots_in_use_ff <= CFG_RESET;
         slot_valid_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         expected_ff   <= expected_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            slots_in_use_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req && req_valid) begin
         frame_seq_ff   <= req_frame_seq;
         payload_tag_ff <= req_payload_tag;
         accepted_ff    <= req_accepted;
      end
      if (cmd.store_slot) begin
         slot_seq_ff[free_idx] <= frame_seq_ff;
         slot_tag_ff[free_idx] <= payload_tag_ff;
      end
      if (cmd.emit) begin
         rsp_last_ff <= cmd.emit_last;
         case (cmd.emit_sel)
            EMIT_SELF_DLV: begin
               rsp_kind_ff <= KIND_DLV;
               rsp_seq_ff  <= frame_seq_ff;
               rsp_tag_ff  <= payload_tag_ff;
            end
            EMIT_SELF_ACK: begin
               rsp_kind_ff <= KIND_ACK;
               rsp_seq_ff  <= frame_seq_ff;
               rsp_tag_ff  <= '0;
            end
            EMIT_SLOT_DLV: begin
               rsp_kind_ff <= KIND_DLV;
               rsp_seq_ff  <= slot_seq_ff[match_idx];
               rsp_tag_ff  <= slot_tag_ff[match_idx];
            end
            default: begin
               rsp_kind_ff <= KIND_ACK;
               rsp_seq_ff  <= frame_seq_ff;
               rsp_tag_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_result_seq  = rsp_seq_ff;
   assign rsp_result_tag  = rsp_tag_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

>>> hw/rtl/srrr_ctrl.sv
// controller state machine: classifies a request and sequences its results
// depends on srrr_pkg
module srrr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  srrr_pkg::sts_type sts,
   output srrr_pkg::cmd_type cmd
);
   import srrr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ACK,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!sts.accepted) begin
               state_in = ST_IDLE;
            end else if (sts.in_order) begin
               if (sts.out_free) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_sel     = EMIT_SELF_DLV;
                  cmd.inc_expected = 1'b1;
                  state_in         = ST_ACK;
               end
            end else if (sts.future && !sts.dup && sts.free_found) begin
               if (sts.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_sel   = EMIT_SELF_ACK;
                  cmd.emit_last  = 1'b1;
                  cmd.store_slot = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACK: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = EMIT_SELF_ACK;
               cmd.emit_last = !sts.match_cur;
               state_in      = sts.match_cur ? ST_DRAIN : ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (sts.out_free) begin
               cmd.emit         = 1'b1;
               cmd.emit_sel     = EMIT_SLOT_DLV;
               cmd.emit_last    = !sts.match_nxt;
               cmd.clear_match  = 1'b1;
               cmd.inc_expected = 1'b1;
               state_in         = sts.match_nxt ? ST_DRAIN : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

>>> hw/rtl/selective_repeat_reorder_receiver.sv
// selective repeat reorder receiver: one request enters while the controller is idle,
// is classified in the next cycle, then its results leave one per cycle, while rsp_stall allows,
// from an output register, paced by the single result register and one slot match per cycle.
// reset (synchronous): expected number zero, all slots free, slots_in_use 8, no result pending.
module selective_repeat_reorder_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [srrr_pkg::SEQ_BITS-1:0] req_frame_seq,
   input  logic [srrr_pkg::TAG_BITS-1:0] req_payload_tag,
   input  logic                          req_accepted,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_result_kind,
   output logic [srrr_pkg::SEQ_BITS-1:0] rsp_result_seq,
   output logic [srrr_pkg::TAG_BITS-1:0] rsp_result_tag,
   output logic                          rsp_last_result,
   input  logic                          csr_wr_en,
   input  logic [srrr_pkg::CFG_BITS-1:0] csr_wr_data
);
   import srrr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   srrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   srrr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_frame_seq   (req_frame_seq),
      .req_payload_tag (req_payload_tag),
      .req_accepted    (req_accepted),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_result_seq  (rsp_result_seq),
      .rsp_result_tag  (rsp_result_tag),
      .rsp_last_result (rsp_last_result),
      .cmd             (cmd),
      .sts             (sts)
   );

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result written while result register is held");

   a_store_is_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.store_slot |-> (sts.future && !sts.dup && sts.free_found && cmd.emit))
      else $error("slot stored without a free slot or with a duplicate");

   a_clear_has_match: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_match |-> (sts.match_cur && cmd.inc_expected))
      else $error("slot freed without a matching number");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous request in progress");

endmodule
